// ===== rtl/mpc_pkg.sv =====
// mpc_pkg: shared types, constants and helpers of the pixel colorizer
// depends on nothing; every rtl module refers to it by scoped names
`default_nettype none
package mpc_pkg;

   // iteration limit, a power of two
   localparam int unsigned ITER_LOG2 = 9;
   localparam int unsigned MAX_ITER  = 1 << ITER_LOG2;
   localparam int unsigned CNT_W     = ITER_LOG2 + 1;

   // field widths
   localparam int unsigned Q_W    = 32;
   localparam int unsigned Q_FRAC = 28;
   localparam int unsigned COL_W  = 11;
   localparam int unsigned ROW_W  = 10;
   localparam int unsigned CH_W   = 8;
   localparam int unsigned ESC_W  = 10;
   localparam int unsigned PAL_W  = 2;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // wide intermediate width used before saturating to q4.28
   localparam int unsigned SAT_W = COL_W + 1 + Q_W + 1;
   localparam int unsigned SQ_W  = 2 * Q_W - Q_FRAC;
   localparam int unsigned XY_W  = 2 * Q_W - (Q_FRAC - 1);

   // coloring
   localparam int unsigned SQR_W   = 2 * CNT_W;
   localparam int unsigned QUAD_W  = 4 * CNT_W;
   localparam int unsigned COEF_W  = 13;
   localparam int unsigned SCALE_W = QUAD_W + COEF_W;
   localparam logic [COEF_W-1:0] COEF_R = COEF_W'(9 * 255);
   localparam logic [COEF_W-1:0] COEF_G = COEF_W'(15 * 255);
   localparam logic [COEF_W-1:0] COEF_B = COEF_W'(17 * 255);

   // queue between front and iteration engine
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register reset values
   localparam logic signed [Q_W-1:0] RE_LEFT_RST = -32'sd536870912;
   localparam logic signed [Q_W-1:0] RE_STEP_RST = 32'sd746172;
   localparam logic signed [Q_W-1:0] IM_TOP_RST  = 32'sd335544320;
   localparam logic signed [Q_W-1:0] IM_STEP_RST = -32'sd746483;

   typedef enum logic [2:0] {
      REG_RE_LEFT,
      REG_RE_STEP,
      REG_IM_TOP,
      REG_IM_STEP,
      REG_PALETTE
   } reg_index_type;

   typedef enum logic [PAL_W-1:0] {
      PAL_RGB,
      PAL_GBR,
      PAL_BGR,
      PAL_BRG
   } palette_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_MUL,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      ITER_IDLE,
      ITER_SQUARE,
      ITER_UPDATE,
      ITER_HANDOFF
   } iter_state_type;

   typedef enum logic [2:0] {
      COLOR_IDLE,
      COLOR_PROD,
      COLOR_CROSS,
      COLOR_SCALE,
      COLOR_OUT
   } color_state_type;

   typedef struct packed {
      logic signed [Q_W-1:0] c_re;
      logic signed [Q_W-1:0] c_im;
   } point_type;

   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] count;
   } handoff_type;

   // clamp to the signed q4.28 range
   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
      logic [SAT_W-Q_W:0]    upper;
      logic signed [Q_W-1:0] res;
      upper = v[SAT_W-1:Q_W-1];
      if ((&upper) || !(|upper)) begin
         res = v[Q_W-1:0];
      end else if (v[SAT_W-1]) begin
         res = {1'b1, {(Q_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(Q_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/mandelbrot_pixel_colorizer.sv =====
// mandelbrot_pixel_colorizer: top level with register port and the three stages
// depends on mpc_pkg, mpc_front, mpc_queue, mpc_iter, mpc_color
//
// One item is one pixel position. The front maps it to c in signed q4.28
// and parks it in a two-entry queue, so the next position can be taken
// while the iteration engine works. Each iteration of the engine is a
// registered square stage, then the escape test and update; coloring runs
// alongside the next pixel's loop. The loop sets the sustained rate. The
// result register holds a finished item while the next pixel is already
// iterating. Registers are to be written only while no item is in flight;
// the block itself does not enforce it.
`default_nettype none
module mandelbrot_pixel_colorizer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [mpc_pkg::COL_W-1:0]          req_column,
   input  logic [mpc_pkg::ROW_W-1:0]          req_row,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mpc_pkg::CH_W-1:0]           rsp_channel_first,
   output logic [mpc_pkg::CH_W-1:0]           rsp_channel_second,
   output logic [mpc_pkg::CH_W-1:0]           rsp_channel_third,
   output logic [mpc_pkg::ESC_W-1:0]          rsp_escape_count,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mpc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [mpc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [mpc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   logic signed [mpc_pkg::Q_W-1:0] re_left_ff, re_left_in;
   logic signed [mpc_pkg::Q_W-1:0] re_step_ff, re_step_in;
   logic signed [mpc_pkg::Q_W-1:0] im_top_ff, im_top_in;
   logic signed [mpc_pkg::Q_W-1:0] im_step_ff, im_step_in;
   logic [mpc_pkg::PAL_W-1:0]      palette_ff, palette_in;
   mpc_pkg::reg_index_type         reg_index;
   logic                           csr_write;

   logic                 queue_full;
   logic                 push;
   mpc_pkg::point_type   push_point;
   logic                 pop;
   logic                 head_valid;
   mpc_pkg::point_type   head_point;
   mpc_pkg::handoff_type handoff;
   logic                 handoff_ready;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign reg_index = mpc_pkg::reg_index_type'(paddr[mpc_pkg::CSR_ADDR_W-1:2]);

   always_comb begin
      re_left_in = re_left_ff;
      re_step_in = re_step_ff;
      im_top_in  = im_top_ff;
      im_step_in = im_step_ff;
      palette_in = palette_ff;
      if (csr_write) begin
         case (reg_index)
            mpc_pkg::REG_RE_LEFT: begin
               re_left_in = pwdata;
            end
            mpc_pkg::REG_RE_STEP: begin
               re_step_in = pwdata;
            end
            mpc_pkg::REG_IM_TOP: begin
               im_top_in = pwdata;
            end
            mpc_pkg::REG_IM_STEP: begin
               im_step_in = pwdata;
            end
            mpc_pkg::REG_PALETTE: begin
               palette_in = pwdata[mpc_pkg::PAL_W-1:0];
            end
            default: begin
               palette_in = palette_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         mpc_pkg::REG_RE_LEFT: begin
            prdata = re_left_ff;
         end
         mpc_pkg::REG_RE_STEP: begin
            prdata = re_step_ff;
         end
         mpc_pkg::REG_IM_TOP: begin
            prdata = im_top_ff;
         end
         mpc_pkg::REG_IM_STEP: begin
            prdata = im_step_ff;
         end
         mpc_pkg::REG_PALETTE: begin
            prdata = mpc_pkg::CSR_DATA_W'(palette_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         re_left_ff <= mpc_pkg::RE_LEFT_RST;
         re_step_ff <= mpc_pkg::RE_STEP_RST;
         im_top_ff  <= mpc_pkg::IM_TOP_RST;
         im_step_ff <= mpc_pkg::IM_STEP_RST;
         palette_ff <= '0;
      end else begin
         re_left_ff <= re_left_in;
         re_step_ff <= re_step_in;
         im_top_ff  <= im_top_in;
         im_step_ff <= im_step_in;
         palette_ff <= palette_in;
      end
   end

   mpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_column (req_column),
      .req_row    (req_row),
      .re_left    (re_left_ff),
      .re_step    (re_step_ff),
      .im_top     (im_top_ff),
      .im_step    (im_step_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_point (push_point)
   );

   mpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_point (push_point),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_point (head_point)
   );

   mpc_iter u_iter (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_point    (head_point),
      .pop           (pop),
      .handoff       (handoff),
      .handoff_ready (handoff_ready)
   );

   mpc_color u_color (
      .clock              (clock),
      .reset              (reset),
      .handoff            (handoff),
      .handoff_ready      (handoff_ready),
      .palette            (palette_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_channel_first  (rsp_channel_first),
      .rsp_channel_second (rsp_channel_second),
      .rsp_channel_third  (rsp_channel_third),
      .rsp_escape_count   (rsp_escape_count)
   );

endmodule
`default_nettype wire

// ===== rtl/mpc_front.sv =====
// mpc_front: takes a pixel position and maps it to the point c
// depends on mpc_pkg; feeds mpc_queue
`default_nettype none
module mpc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [mpc_pkg::COL_W-1:0]    req_column,
   input  logic [mpc_pkg::ROW_W-1:0]    req_row,
   input  logic signed [mpc_pkg::Q_W-1:0] re_left,
   input  logic signed [mpc_pkg::Q_W-1:0] re_step,
   input  logic signed [mpc_pkg::Q_W-1:0] im_top,
   input  logic signed [mpc_pkg::Q_W-1:0] im_step,
   input  logic                         queue_full,
   output logic                         push,
   output mpc_pkg::point_type           push_point
);

   localparam int unsigned PRE_W = mpc_pkg::COL_W + 1 + mpc_pkg::Q_W;
   localparam int unsigned PIM_W = mpc_pkg::ROW_W + 1 + mpc_pkg::Q_W;

   mpc_pkg::front_state_type state_ff, state_in;
   logic [mpc_pkg::COL_W-1:0] col_ff;
   logic [mpc_pkg::ROW_W-1:0] row_ff;
   logic signed [PRE_W-1:0]   prod_re_ff, prod_re_in;
   logic signed [PIM_W-1:0]   prod_im_ff, prod_im_in;
   logic                      capture;
   logic                      mul_en;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mpc_pkg::FRONT_IDLE: begin
            if (req_valid) begin
               state_in = mpc_pkg::FRONT_MUL;
            end
         end
         mpc_pkg::FRONT_MUL: begin
            state_in = mpc_pkg::FRONT_PUSH;
         end
         mpc_pkg::FRONT_PUSH: begin
            if (!queue_full) begin
               state_in = mpc_pkg::FRONT_IDLE;
            end
         end
         default: begin
            state_in = mpc_pkg::FRONT_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      push      = 1'b0;
      capture   = 1'b0;
      mul_en    = 1'b0;
      case (state_ff)
         mpc_pkg::FRONT_IDLE: begin
            req_ready = 1'b1;
            capture   = req_valid;
         end
         mpc_pkg::FRONT_MUL: begin
            mul_en = 1'b1;
         end
         mpc_pkg::FRONT_PUSH: begin
            push = !queue_full;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign prod_re_in = $signed({1'b0, col_ff}) * re_step;
   assign prod_im_in = $signed({1'b0, row_ff}) * im_step;

   assign push_point.c_re = mpc_pkg::sat_q(mpc_pkg::SAT_W'(prod_re_ff)
                                           + mpc_pkg::SAT_W'(re_left));
   assign push_point.c_im = mpc_pkg::sat_q(mpc_pkg::SAT_W'(prod_im_ff)
                                           + mpc_pkg::SAT_W'(im_top));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpc_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         col_ff <= req_column;
         row_ff <= req_row;
      end
      if (mul_en) begin
         prod_re_ff <= prod_re_in;
         prod_im_ff <= prod_im_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/mpc_queue.sv =====
// mpc_queue: short register queue of mapped points
// depends on mpc_pkg; sits between mpc_front and mpc_iter
`default_nettype none
module mpc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mpc_pkg::point_type push_point,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output mpc_pkg::point_type head_point
);

   mpc_pkg::point_type entries_ff [mpc_pkg::QUEUE_DEPTH];
   logic [mpc_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mpc_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mpc_pkg::QCNT_W-1:0] count_ff, count_in;

   function automatic logic [mpc_pkg::QPTR_W-1:0] next_ptr(
      input logic [mpc_pkg::QPTR_W-1:0] p);
      logic [mpc_pkg::QPTR_W-1:0] res;
      if (p == mpc_pkg::QPTR_W'(mpc_pkg::QUEUE_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = p + mpc_pkg::QPTR_W'(1);
      end
      return res;
   endfunction

   assign full       = (count_ff == mpc_pkg::QCNT_W'(mpc_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_point = entries_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
   assign rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
   assign count_in  = count_ff + mpc_pkg::QCNT_W'(push) - mpc_pkg::QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_point;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> !pop)
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mpc_pkg::QCNT_W'(mpc_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

// ===== rtl/mpc_iter.sv =====
// mpc_iter: escape-time loop z = z*z + c, squares then update per iteration
// depends on mpc_pkg; pops mpc_queue and hands the count to mpc_color
`default_nettype none
module mpc_iter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  mpc_pkg::point_type   head_point,
   output logic                 pop,
   output mpc_pkg::handoff_type handoff,
   input  logic                 handoff_ready
);

   localparam logic signed [mpc_pkg::SQ_W:0] ESC_LIMIT =
      (mpc_pkg::SQ_W + 1)'(64'd4 << mpc_pkg::Q_FRAC);

   mpc_pkg::iter_state_type state_ff, state_in;
   logic signed [mpc_pkg::Q_W-1:0]  c_re_ff, c_im_ff;
   logic signed [mpc_pkg::Q_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [mpc_pkg::SQ_W-1:0] xx_ff, yy_ff;
   logic signed [mpc_pkg::XY_W-1:0] xy_ff;
   logic [mpc_pkg::CNT_W-1:0]       n_ff, n_in;
   logic signed [2*mpc_pkg::Q_W-1:0] pxx, pyy, pxy;
   logic signed [mpc_pkg::SQ_W:0]   mag_sum;
   logic                            escape;
   logic                            last;
   logic                            sq_en;
   logic                            step_en;

   assign mag_sum = (mpc_pkg::SQ_W + 1)'(xx_ff) + (mpc_pkg::SQ_W + 1)'(yy_ff);
   assign escape  = (mag_sum > ESC_LIMIT);
   assign last    = (n_ff == mpc_pkg::CNT_W'(mpc_pkg::MAX_ITER - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mpc_pkg::ITER_IDLE: begin
            if (head_valid) begin
               state_in = mpc_pkg::ITER_SQUARE;
            end
         end
         mpc_pkg::ITER_SQUARE: begin
            state_in = mpc_pkg::ITER_UPDATE;
         end
         mpc_pkg::ITER_UPDATE: begin
            if (escape || last) begin
               state_in = mpc_pkg::ITER_HANDOFF;
            end else begin
               state_in = mpc_pkg::ITER_SQUARE;
            end
         end
         mpc_pkg::ITER_HANDOFF: begin
            if (handoff_ready) begin
               state_in = mpc_pkg::ITER_IDLE;
            end
         end
         default: begin
            state_in = mpc_pkg::ITER_IDLE;
         end
      endcase
   end

   always_comb begin
      pop           = 1'b0;
      sq_en         = 1'b0;
      step_en       = 1'b0;
      handoff.valid = 1'b0;
      handoff.count = n_ff;
      case (state_ff)
         mpc_pkg::ITER_IDLE: begin
            pop = head_valid;
         end
         mpc_pkg::ITER_SQUARE: begin
            sq_en = 1'b1;
         end
         mpc_pkg::ITER_UPDATE: begin
            step_en = !escape;
         end
         mpc_pkg::ITER_HANDOFF: begin
            handoff.valid = 1'b1;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   assign pxx = x_ff * x_ff;
   assign pyy = y_ff * y_ff;
   assign pxy = x_ff * y_ff;

   assign x_in = mpc_pkg::sat_q(mpc_pkg::SAT_W'(xx_ff) - mpc_pkg::SAT_W'(yy_ff)
                                + mpc_pkg::SAT_W'(c_re_ff));
   assign y_in = mpc_pkg::sat_q(mpc_pkg::SAT_W'(xy_ff) + mpc_pkg::SAT_W'(c_im_ff));
   assign n_in = n_ff + mpc_pkg::CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpc_pkg::ITER_IDLE;
         n_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (pop) begin
            n_ff <= '0;
         end else if (step_en) begin
            n_ff <= n_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         c_re_ff <= head_point.c_re;
         c_im_ff <= head_point.c_im;
         x_ff    <= '0;
         y_ff    <= '0;
      end else if (step_en) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
      if (sq_en) begin
         xx_ff <= pxx[2*mpc_pkg::Q_W-1:mpc_pkg::Q_FRAC];
         yy_ff <= pyy[2*mpc_pkg::Q_W-1:mpc_pkg::Q_FRAC];
         xy_ff <= pxy[2*mpc_pkg::Q_W-1:mpc_pkg::Q_FRAC-1];
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= mpc_pkg::CNT_W'(mpc_pkg::MAX_ITER))
      else $error("iteration count beyond limit");

   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      pop |=> (n_ff == '0) && (state_ff == mpc_pkg::ITER_SQUARE))
      else $error("new point did not start from zero");

   a_square_below_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mpc_pkg::ITER_SQUARE) |-> (n_ff < mpc_pkg::CNT_W'(mpc_pkg::MAX_ITER)))
      else $error("iteration past limit");
`endif

endmodule
`default_nettype wire

// ===== rtl/mpc_color.sv =====
// mpc_color: polynomial coloring of the count, palette order, result register
// depends on mpc_pkg; takes counts from mpc_iter
`default_nettype none
module mpc_color (
   input  logic                          clock,
   input  logic                          reset,
   input  mpc_pkg::handoff_type          handoff,
   output logic                          handoff_ready,
   input  logic [mpc_pkg::PAL_W-1:0]     palette,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mpc_pkg::CH_W-1:0]      rsp_channel_first,
   output logic [mpc_pkg::CH_W-1:0]      rsp_channel_second,
   output logic [mpc_pkg::CH_W-1:0]      rsp_channel_third,
   output logic [mpc_pkg::ESC_W-1:0]     rsp_escape_count
);

   localparam int unsigned SHIFT = 4 * mpc_pkg::ITER_LOG2;

   mpc_pkg::color_state_type state_ff, state_in;
   logic [mpc_pkg::CNT_W-1:0]   n_ff, k_ff;
   logic [mpc_pkg::SQR_W-1:0]   n2_ff, k2_ff, nk_ff;
   logic [mpc_pkg::QUAD_W-1:0]  r1_ff, g1_ff, b1_ff;
   logic [mpc_pkg::SCALE_W-1:0] r2_ff, g2_ff, b2_ff;
   logic [mpc_pkg::CH_W-1:0]    r, g, b;
   logic [mpc_pkg::CH_W-1:0]    c0, c1, c2;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [mpc_pkg::CH_W-1:0]    ch0_ff, ch1_ff, ch2_ff;
   logic [mpc_pkg::ESC_W-1:0]   count_ff;
   logic                        take;
   logic                        load;
   logic                        out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mpc_pkg::COLOR_IDLE: begin
            if (handoff.valid) begin
               state_in = mpc_pkg::COLOR_PROD;
            end
         end
         mpc_pkg::COLOR_PROD: begin
            state_in = mpc_pkg::COLOR_CROSS;
         end
         mpc_pkg::COLOR_CROSS: begin
            state_in = mpc_pkg::COLOR_SCALE;
         end
         mpc_pkg::COLOR_SCALE: begin
            state_in = mpc_pkg::COLOR_OUT;
         end
         mpc_pkg::COLOR_OUT: begin
            if (out_free) begin
               state_in = mpc_pkg::COLOR_IDLE;
            end
         end
         default: begin
            state_in = mpc_pkg::COLOR_IDLE;
         end
      endcase
   end

   always_comb begin
      handoff_ready = 1'b0;
      take          = 1'b0;
      load          = 1'b0;
      case (state_ff)
         mpc_pkg::COLOR_IDLE: begin
            handoff_ready = 1'b1;
            take          = handoff.valid;
         end
         mpc_pkg::COLOR_OUT: begin
            load = out_free;
         end
         default: begin
            handoff_ready = 1'b0;
         end
      endcase
   end

   assign r = r2_ff[SHIFT +: mpc_pkg::CH_W];
   assign g = g2_ff[SHIFT +: mpc_pkg::CH_W];
   assign b = b2_ff[SHIFT + 1 +: mpc_pkg::CH_W];

   always_comb begin
      case (mpc_pkg::palette_type'(palette))
         mpc_pkg::PAL_RGB: begin
            c0 = r; c1 = g; c2 = b;
         end
         mpc_pkg::PAL_GBR: begin
            c0 = g; c1 = b; c2 = r;
         end
         mpc_pkg::PAL_BGR: begin
            c0 = b; c1 = g; c2 = r;
         end
         default: begin
            c0 = b; c1 = r; c2 = g;
         end
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpc_pkg::COLOR_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         n_ff <= handoff.count;
         k_ff <= mpc_pkg::CNT_W'(mpc_pkg::MAX_ITER) - handoff.count;
      end
      if (state_ff == mpc_pkg::COLOR_PROD) begin
         n2_ff <= n_ff * n_ff;
         k2_ff <= k_ff * k_ff;
         nk_ff <= n_ff * k_ff;
      end
      if (state_ff == mpc_pkg::COLOR_CROSS) begin
         r1_ff <= nk_ff * n2_ff;
         g1_ff <= n2_ff * k2_ff;
         b1_ff <= nk_ff * k2_ff;
      end
      if (state_ff == mpc_pkg::COLOR_SCALE) begin
         r2_ff <= r1_ff * mpc_pkg::COEF_R;
         g2_ff <= g1_ff * mpc_pkg::COEF_G;
         b2_ff <= b1_ff * mpc_pkg::COEF_B;
      end
      if (load) begin
         ch0_ff   <= c0;
         ch1_ff   <= c1;
         ch2_ff   <= c2;
         count_ff <= mpc_pkg::ESC_W'(n_ff);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_channel_first  = ch0_ff;
   assign rsp_channel_second = ch1_ff;
   assign rsp_channel_third  = ch2_ff;
   assign rsp_escape_count   = count_ff;

`ifndef SYNTH
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      take |-> (handoff.count <= mpc_pkg::CNT_W'(mpc_pkg::MAX_ITER)))
      else $error("count beyond limit at coloring");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !load)
      else $error("result register overwritten while held");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid && (state_ff == mpc_pkg::COLOR_IDLE))
      else $error("loaded result not shown");
`endif

endmodule
`default_nettype wire

// ===== sim/mandelbrot_pixel_colorizer_test.sv =====
// mandelbrot_pixel_colorizer_test: self-checking bench for the pixel colorizer
// drives pixel positions and apb register writes, predicts escape count and colors
// depends on mpc_pkg and mandelbrot_pixel_colorizer
`timescale 1ns / 1ps
module mandelbrot_pixel_colorizer_test;

   typedef struct packed {
      logic [mpc_pkg::CH_W-1:0]  ch_first;
      logic [mpc_pkg::CH_W-1:0]  ch_second;
      logic [mpc_pkg::CH_W-1:0]  ch_third;
      logic [mpc_pkg::ESC_W-1:0] count;
   } color_type;

   typedef struct packed {
      logic [mpc_pkg::COL_W-1:0] column;
      logic [mpc_pkg::ROW_W-1:0] row;
      logic                      interior;
   } probe_type;

   localparam logic [31:0] DEF_RE_LEFT = -32'sd536870912;
   localparam logic [31:0] DEF_RE_STEP = 32'sd746172;
   localparam logic [31:0] DEF_IM_TOP  = 32'sd335544320;
   localparam logic [31:0] DEF_IM_STEP = -32'sd746483;

   // reset mapping; interior points near the origin and on the main cardioid
   localparam probe_type PROBES [14] = '{
      '{11'd0,    10'd0,   1'b0},
      '{11'd630,  10'd450, 1'b1},
      '{11'd720,  10'd450, 1'b1},
      '{11'd2047, 10'd1023, 1'b0},
      '{11'd1439, 10'd899, 1'b0},
      '{11'd1440, 10'd900, 1'b0},
      '{11'd0,    10'd450, 1'b0},
      '{11'd1,    10'd1,   1'b0},
      '{11'd2046, 10'd1022, 1'b0},
      '{11'd1024, 10'd512, 1'b0},
      '{11'd360,  10'd225, 1'b0},
      '{11'd100,  10'd800, 1'b0},
      '{11'd1365, 10'd682, 1'b0},
      '{11'd682,  10'd341, 1'b0}
   };

   localparam logic [mpc_pkg::COL_W-1:0] CORNER_COL [4] = '{11'd0, 11'd1, 11'd2047, 11'd3};
   localparam logic [mpc_pkg::ROW_W-1:0] CORNER_ROW [4] = '{10'd0, 10'd1, 10'd1023, 10'd2};

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [mpc_pkg::COL_W-1:0]      req_column = '0;
   logic [mpc_pkg::ROW_W-1:0]      req_row = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [mpc_pkg::CH_W-1:0]       rsp_channel_first;
   logic [mpc_pkg::CH_W-1:0]       rsp_channel_second;
   logic [mpc_pkg::CH_W-1:0]       rsp_channel_third;
   logic [mpc_pkg::ESC_W-1:0]      rsp_escape_count;
   logic                           psel = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite = 1'b0;
   logic [mpc_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [mpc_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [mpc_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   logic signed [31:0]   set_re_left = DEF_RE_LEFT;
   logic signed [31:0]   set_re_step = DEF_RE_STEP;
   logic signed [31:0]   set_im_top  = DEF_IM_TOP;
   logic signed [31:0]   set_im_step = DEF_IM_STEP;
   mpc_pkg::palette_type set_palette = mpc_pkg::PAL_RGB;

   color_type pending_colors [$];
   logic   idle_on = 1'b1;
   int     stall_left = 0;
   int     mismatches = 0;
   int     items_sent = 0;
   int     results_seen = 0;
   int     interior_seen = 0;
   int     settings_used = 0;

   mandelbrot_pixel_colorizer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_column(req_column),
      .req_row(req_row),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_channel_first(rsp_channel_first),
      .rsp_channel_second(rsp_channel_second),
      .rsp_channel_third(rsp_channel_third),
      .rsp_escape_count(rsp_escape_count),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   initial begin
      #40ms;
      $display("TEST FAILED");
      $finish;
   end

   function automatic longint clamp_q428(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic color_type escape_color(input logic [mpc_pkg::COL_W-1:0] col,
                                              input logic [mpc_pkg::ROW_W-1:0] row);
      longint c_re, c_im, x, y, xx, yy, nx;
      longint unsigned n, k, m, m4, red, green, blue;
      color_type p;
      c_re = clamp_q428(longint'(set_re_left) + longint'(col) * longint'(set_re_step));
      c_im = clamp_q428(longint'(set_im_top) + longint'(row) * longint'(set_im_step));
      x = 0;
      y = 0;
      n = 0;
      m = 64'(mpc_pkg::MAX_ITER);
      while (n < m) begin
         xx = (x * x) >>> mpc_pkg::Q_FRAC;
         yy = (y * y) >>> mpc_pkg::Q_FRAC;
         if (xx + yy > (64'sd4 <<< mpc_pkg::Q_FRAC)) break;
         nx = clamp_q428(xx - yy + c_re);
         y = clamp_q428(((x * y) >>> (mpc_pkg::Q_FRAC - 1)) + c_im);
         x = nx;
         n++;
      end
      k = m - n;
      m4 = m * m * m * m;
      red   = (64'd2295 * k * n * n * n) / m4;
      green = (64'd3825 * k * k * n * n) / m4;
      blue  = (64'd4335 * k * k * k * n) / (64'd2 * m4);
      case (set_palette)
         mpc_pkg::PAL_RGB: begin
            p.ch_first = red[7:0]; p.ch_second = green[7:0]; p.ch_third = blue[7:0];
         end
         mpc_pkg::PAL_GBR: begin
            p.ch_first = green[7:0]; p.ch_second = blue[7:0]; p.ch_third = red[7:0];
         end
         mpc_pkg::PAL_BGR: begin
            p.ch_first = blue[7:0]; p.ch_second = green[7:0]; p.ch_third = red[7:0];
         end
         default: begin
            p.ch_first = blue[7:0]; p.ch_second = red[7:0]; p.ch_third = green[7:0];
         end
      endcase
      p.count = n[mpc_pkg::ESC_W-1:0];
      return p;
   endfunction

   task automatic csr_write(input mpc_pkg::reg_index_type idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         mpc_pkg::REG_RE_LEFT: set_re_left = value;
         mpc_pkg::REG_RE_STEP: set_re_step = value;
         mpc_pkg::REG_IM_TOP:  set_im_top = value;
         mpc_pkg::REG_IM_STEP: set_im_step = value;
         default:              set_palette = mpc_pkg::palette_type'(value[mpc_pkg::PAL_W-1:0]);
      endcase
      @(posedge clock);
   endtask

   task automatic csr_check(input mpc_pkg::reg_index_type idx, input logic [31:0] want);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         $error("register %s: expected %h, got %h", idx.name(), want, prdata);
         mismatches++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_all_regs();
      csr_check(mpc_pkg::REG_RE_LEFT, set_re_left);
      csr_check(mpc_pkg::REG_RE_STEP, set_re_step);
      csr_check(mpc_pkg::REG_IM_TOP, set_im_top);
      csr_check(mpc_pkg::REG_IM_STEP, set_im_step);
      csr_check(mpc_pkg::REG_PALETTE, {30'd0, set_palette});
   endtask

   task automatic apply_settings(input logic [31:0] re_left, input logic [31:0] re_step,
                                 input logic [31:0] im_top, input logic [31:0] im_step,
                                 input mpc_pkg::palette_type pal);
      csr_write(mpc_pkg::REG_RE_LEFT, re_left);
      csr_write(mpc_pkg::REG_RE_STEP, re_step);
      csr_write(mpc_pkg::REG_IM_TOP, im_top);
      csr_write(mpc_pkg::REG_IM_STEP, im_step);
      csr_write(mpc_pkg::REG_PALETTE, {30'd0, pal});
      check_all_regs();
      settings_used++;
   endtask

   task automatic send_pixel(input logic [mpc_pkg::COL_W-1:0] col,
                             input logic [mpc_pkg::ROW_W-1:0] row,
                             input color_type want);
      req_valid <= 1'b1;
      req_column <= col;
      req_row <= row;
      do @(posedge clock); while (!req_ready);
      pending_colors.push_back(want);
      items_sent++;
   endtask

   task automatic sender_gap();
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int n_random);
      logic [mpc_pkg::COL_W-1:0] col;
      logic [mpc_pkg::ROW_W-1:0] row;
      for (int i = 0; i < 4 + n_random; i++) begin
         if (i < 4) begin
            col = CORNER_COL[i];
            row = CORNER_ROW[i];
         end else if ($urandom_range(0, 3) == 0) begin
            col = mpc_pkg::COL_W'($urandom_range(0, 2047));
            row = mpc_pkg::ROW_W'($urandom_range(0, 1023));
         end else begin
            col = mpc_pkg::COL_W'($urandom_range(0, 1439));
            row = mpc_pkg::ROW_W'($urandom_range(0, 899));
         end
         sender_gap();
         send_pixel(col, row, escape_color(col, row));
      end
      drain();
   endtask

   // result side back-pressure
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 18);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      color_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_colors.size() == 0) begin
            $error("result item with no pixel outstanding");
            mismatches++;
         end else begin
            want = pending_colors.pop_front();
            results_seen++;
            if (rsp_escape_count == mpc_pkg::ESC_W'(mpc_pkg::MAX_ITER)) interior_seen++;
            if (rsp_channel_first !== want.ch_first) begin
               $error("channel_first: expected %0d, got %0d", want.ch_first,
                      rsp_channel_first);
               mismatches++;
            end
            if (rsp_channel_second !== want.ch_second) begin
               $error("channel_second: expected %0d, got %0d", want.ch_second,
                      rsp_channel_second);
               mismatches++;
            end
            if (rsp_channel_third !== want.ch_third) begin
               $error("channel_third: expected %0d, got %0d", want.ch_third,
                      rsp_channel_third);
               mismatches++;
            end
            if (rsp_escape_count !== want.count) begin
               $error("escape_count: expected %0d, got %0d", want.count,
                      rsp_escape_count);
               mismatches++;
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      check_all_regs();

      // directed probes at the reset mapping
      for (int i = 0; i < 14; i++) begin
         sender_gap();
         if (PROBES[i].interior) begin
            send_pixel(PROBES[i].column, PROBES[i].row, '{8'd0, 8'd0, 8'd0, 10'd512});
         end else begin
            send_pixel(PROBES[i].column, PROBES[i].row,
                       escape_color(PROBES[i].column, PROBES[i].row));
         end
      end
      drain();

      apply_settings(DEF_RE_LEFT, DEF_RE_STEP, DEF_IM_TOP, DEF_IM_STEP, mpc_pkg::PAL_GBR);
      run_phase(60);
      // zoom near the seahorse valley
      apply_settings(-32'sd214748365, 32'sd16384, 32'sd53687091, -32'sd16384,
                     mpc_pkg::PAL_BGR);
      run_phase(70);
      apply_settings(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                     mpc_pkg::PAL_BRG);
      run_phase(60);
      apply_settings(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                     mpc_pkg::PAL_RGB);
      run_phase(60);
      // every pixel at the origin runs the full iteration limit
      apply_settings(32'd0, 32'd0, 32'd0, 32'd0, mpc_pkg::PAL_GBR);
      run_phase(6);
      apply_settings($urandom, $urandom, $urandom, $urandom,
                     mpc_pkg::palette_type'($urandom_range(0, 3)));
      run_phase(60);
      idle_on <= 1'b0;
      apply_settings(DEF_RE_LEFT, DEF_RE_STEP, DEF_IM_TOP, DEF_IM_STEP, mpc_pkg::PAL_RGB);
      run_phase(100);

      repeat (40) @(posedge clock);
      $display("%0d pixels sent under %0d register settings, all four palettes",
               items_sent, settings_used);
      $display("%0d results checked, %0d of them at the iteration limit",
               results_seen, interior_seen);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
